@@ hw/rtl/atqp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atqp_pkg
// Shared types and constants for the angle to quadrature pulse emulator.
// ----------------------------------------------------------------------------
package atqp_pkg;

    // field widths
    localparam int ANGLE_W = 20;
    localparam int PITCH_W = 19;
    localparam int SLOT_W  = 40;

    // millidegrees in one full turn
    localparam logic signed [ANGLE_W-1:0] FULL_TURN_MDEG = 20'sd360000;

    // slot pitch after reset, 360000 / 112
    localparam logic [PITCH_W-1:0] PITCH_RESET = 19'd3214;

    // index of the last of the four phases in one quadrature pulse
    localparam logic [1:0] LAST_PHASE = 2'd3;

    // sequencer states
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_ADD  = 9'b000000100,
        S_CHKF = 9'b000001000,
        S_CHKR = 9'b000010000,
        S_DIV  = 9'b000100000,
        S_ADJ  = 9'b001000000,
        S_UPD  = 9'b010000000,
        S_EMIT = 9'b100000000
    } atqp_state_t;

    // status of the remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } atqp_rem_status_t;

    // channel levels {a, b} for a phase of a forward or reverse pulse
    function automatic logic [1:0] phase_levels(input logic [1:0] phase,
                                                input logic       rev);
        logic fwd_a;
        logic fwd_b;
        fwd_a = (phase == 2'd0) || (phase == 2'd1);
        fwd_b = (phase == 2'd1) || (phase == 2'd2);
        return rev ? {fwd_b, fwd_a} : {fwd_a, fwd_b};
    endfunction

endpackage

@@ hw/rtl/atqp_rem_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atqp_rem_unit
// Restoring remainder unit: one dividend bit per cycle through a shared
// compare and subtract against the slot pitch.
// ----------------------------------------------------------------------------
module atqp_rem_unit
    import atqp_pkg::*;
#(
    parameter int DW = 42
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [DW-1:0]          dividend,
    input  logic [PITCH_W-1:0]     divisor,
    output atqp_rem_status_t       status,
    output logic [PITCH_W-1:0]     remainder
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               busy_reg;
    logic               busy_next;
    logic               done_reg;
    logic               done_next;
    logic [DW-1:0]      quo_reg;
    logic [DW-1:0]      quo_next;
    logic [PITCH_W-1:0] rem_reg;
    logic [PITCH_W-1:0] rem_next;
    logic [PITCH_W:0]   rem_shift;
    logic [PITCH_W:0]   rem_sub;

    // shared compare and subtract step
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DW-1]};
        rem_sub   = rem_shift - {1'b0, divisor};
    end

    // iteration control
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            cnt_next  = CNT_W'(DW);
            busy_next = 1'b1;
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DW-2:0], 1'b0};
            if (rem_shift >= {1'b0, divisor})
            begin
                rem_next = rem_sub[PITCH_W-1:0];
            end
            else
            begin
                rem_next = rem_shift[PITCH_W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

endmodule

@@ hw/rtl/angle_to_quadrature_pulses.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_to_quadrature_pulses
// Quadrature encoder emulator driven by a yaw angle stream.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with angle_mdeg, signed millidegrees.
// An item is taken when in_valid is high and in_stall is low. in_stall stays
// high from the accepted item until its last phase, if it has any, is taken.
// Output channel: out_valid / out_stall with pin_a, pin_b, direction, last.
// An item that passes the next slot yields four phase items, the fourth with
// last set; an item that passes no slot yields nothing.
// Steps: unwrap multiply, add, one or two range checks, then a remainder
// pass over W dividend bits (W = max(REV_COUNT_BITS + 21, 42), 42 by
// default), an adjust and an update that move the slot, and the four
// phases. An item that passes no slot ends after its range checks.
// The remainder unit takes one dividend bit per cycle.
// The receiver may stall any phase; the phase item holds until taken.
// Reset clears the revolution count, previous sample and slot angle, and
// loads the slot pitch with 3214. cfg_wr_en writes the pitch; write it only
// while idle, the block does not enforce this. A pitch of zero acts as one.
// ----------------------------------------------------------------------------
module angle_to_quadrature_pulses
    import atqp_pkg::*;
#(
    parameter int REV_COUNT_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [PITCH_W-1:0]        cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [ANGLE_W-1:0] angle_mdeg,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      pin_a,
    output logic                      pin_b,
    output logic                      direction,
    output logic                      last
);

    localparam int WIDE   = (REV_COUNT_BITS + 21 > 42) ? REV_COUNT_BITS + 21 : 42;
    localparam int PROD_W = REV_COUNT_BITS + ANGLE_W;

    atqp_state_t                      state_reg;
    atqp_state_t                      state_next;
    logic [PITCH_W-1:0]               pitch_reg;
    logic signed [ANGLE_W-1:0]        prev_reg;
    logic signed [REV_COUNT_BITS-1:0] rev_reg;
    logic signed [REV_COUNT_BITS-1:0] rev_next;
    logic signed [SLOT_W-1:0]         slot_reg;
    logic                             dir_reg;
    logic                             dir_next;
    logic [1:0]                       phase_reg;

    logic signed [REV_COUNT_BITS-1:0] rev_snap_reg;
    logic signed [ANGLE_W-1:0]        cur_reg;
    logic signed [PROD_W-1:0]         prod_reg;
    logic signed [WIDE-1:0]           smp_reg;
    logic signed [WIDE-1:0]           unwrap_reg;
    logic [PITCH_W-1:0]               add_reg;

    logic [PITCH_W-1:0]               pitch_eff;
    logic signed [WIDE-1:0]           pitch_wide;
    logic signed [WIDE-1:0]           slot_wide;
    logic signed [WIDE-1:0]           diff_f;
    logic signed [WIDE-1:0]           diff_r;
    logic                             fwd_hit;
    logic                             rev_hit;
    logic                             in_accept;
    logic                             out_accept;
    logic                             rem_start;
    logic [WIDE-1:0]                  rem_dividend;
    atqp_rem_status_t                 rem_status;
    logic [PITCH_W-1:0]               rem_value;
    logic [PITCH_W-1:0]               add_next;
    logic [1:0]                       levels;

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;
    assign in_stall   = (state_reg != S_IDLE);

    // effective pitch and wide operands
    always_comb
    begin
        pitch_eff  = (pitch_reg == '0) ? PITCH_W'(1) : pitch_reg;
        pitch_wide = WIDE'($signed({1'b0, pitch_eff}));
        slot_wide  = WIDE'(slot_reg);
        diff_f     = unwrap_reg - slot_wide;
        diff_r     = smp_reg - unwrap_reg;
        fwd_hit    = !diff_f[WIDE-1] && (diff_f != '0);
        rev_hit    = !diff_r[WIDE-1] && (diff_r != '0);
    end

    // revolution count moves when the sample lands on zero
    always_comb
    begin
        rev_next = rev_reg;
        if (angle_mdeg == '0)
        begin
            if (prev_reg > 0)
            begin
                rev_next = rev_reg + 1'b1;
            end
            else if (prev_reg < 0)
            begin
                rev_next = rev_reg - 1'b1;
            end
        end
    end

    // remainder unit start and operand
    assign rem_start    = ((state_reg == S_CHKF) && fwd_hit) ||
                          ((state_reg == S_CHKR) && rev_hit);
    assign rem_dividend = (state_reg == S_CHKF) ? $unsigned(diff_f) : $unsigned(diff_r);

    atqp_rem_unit #(
        .DW (WIDE)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (rem_dividend),
        .divisor   (pitch_eff),
        .status    (rem_status),
        .remainder (rem_value)
    );

    // distance from the unwrapped angle to the new slot
    always_comb
    begin
        if (dir_reg)
        begin
            add_next = (rem_value == '0) ? pitch_eff : rem_value;
        end
        else
        begin
            add_next = (rem_value == '0) ? '0 : pitch_eff - rem_value;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        dir_next   = dir_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                state_next = S_CHKF;
            end
            S_CHKF:
            begin
                if (fwd_hit)
                begin
                    dir_next   = 1'b0;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_CHKR;
                end
            end
            S_CHKR:
            begin
                if (rev_hit)
                begin
                    dir_next   = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (rem_status.done)
                begin
                    state_next = S_ADJ;
                end
            end
            S_ADJ:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_accept && (phase_reg == LAST_PHASE))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pitch_reg <= PITCH_RESET;
            prev_reg  <= '0;
            rev_reg   <= '0;
            slot_reg  <= '0;
            dir_reg   <= 1'b0;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dir_reg   <= dir_next;
            if (cfg_wr_en)
            begin
                pitch_reg <= cfg_wr_data;
            end
            if (in_accept)
            begin
                prev_reg <= angle_mdeg;
                rev_reg  <= rev_next;
            end
            if (state_reg == S_UPD)
            begin
                slot_reg  <= SLOT_W'(unwrap_reg + WIDE'($signed({1'b0, add_reg})));
                phase_reg <= '0;
            end
            else if (out_accept)
            begin
                phase_reg <= phase_reg + 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rev_snap_reg <= rev_reg;
            cur_reg      <= angle_mdeg;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= rev_snap_reg * FULL_TURN_MDEG;
            smp_reg  <= slot_wide - pitch_wide;
        end
        if (state_reg == S_ADD)
        begin
            unwrap_reg <= WIDE'(prod_reg) + WIDE'(cur_reg);
        end
        if (state_reg == S_ADJ)
        begin
            add_reg <= add_next;
        end
    end

    // phase item
    assign levels    = phase_levels(phase_reg, dir_reg);
    assign out_valid = (state_reg == S_EMIT);
    assign pin_a     = levels[1];
    assign pin_b     = levels[0];
    assign direction = dir_reg;
    assign last      = (phase_reg == LAST_PHASE);

endmodule
